/* design/c3zp_pkg.sv */
`default_nettype none

package c3zp_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int KERNEL_SIZE  = 3;

  // Field and register widths.
  localparam int PIX_W    = 16;
  localparam int COEF_W   = 16;
  localparam int KROW_W   = KERNEL_SIZE * COEF_W;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int CFG_W    = KROW_W;
  localparam int CFG_IDX_W = 3;

  // Counter widths derived from the geometry limits.
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(HEIGHT_LIMIT);
  localparam int TOTAL_W = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 1);
  localparam int POS_W   = $clog2(MAX_WIDTH * HEIGHT_LIMIT + MAX_WIDTH + 2);

  // Datapath widths: products, row sums, full sum.
  localparam int PROD_W     = PIX_W + COEF_W;
  localparam int RSUM_W     = PROD_W + 2;
  localparam int ACC_W      = RSUM_W + 2;
  localparam int FRAC_SHIFT = 12;
  localparam int PIX_MAX    = 32767;
  localparam int PIX_MIN    = -32768;

  // Result queue sizing.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_KERNEL_TOP    = 3'd2,
    CFG_KERNEL_MID    = 3'd3,
    CFG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_t;

  typedef logic signed [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t pixel_value;
    logic mode;
  } in_item_t;

  typedef struct packed {
    pix_t filtered_value;
    logic frame_end;
  } out_item_t;

  // One word of the line store: pixel one row back and two rows back.
  typedef struct packed {
    pix_t near_row;
    pix_t far_row;
  } line_word_t;

  // One window column, oldest row first.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bottom;
  } column_t;

  // Per-item control that travels with a column into the datapath.
  typedef struct packed {
    logic out_en;
    logic last;
    logic top_ok;
    logic bottom_ok;
    logic left_ok;
    logic right_ok;
  } mac_ctrl_t;

  typedef logic [KERNEL_SIZE-1:0][KROW_W-1:0] kernel_t;

  // Clamp a written width to the supported range.
  function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] raw);
    logic [WIDTH_W-1:0] res;
    if (raw == '0) begin
      res = WIDTH_W'(1);
    end else if (int'(raw) > MAX_WIDTH) begin
      res = WIDTH_W'(MAX_WIDTH);
    end else begin
      res = raw;
    end
    return res;
  endfunction

  // Clamp a written height to the supported range.
  function automatic logic [HEIGHT_W-1:0] eff_height(input logic [HEIGHT_W-1:0] raw);
    logic [HEIGHT_W-1:0] res;
    if (raw == '0) begin
      res = HEIGHT_W'(1);
    end else if (int'(raw) > HEIGHT_LIMIT) begin
      res = HEIGHT_W'(HEIGHT_LIMIT);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/c3zp_line_store.sv */
`default_nettype none

module c3zp_line_store
  import c3zp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [COL_W-1:0] rd_addr,
  input  wire logic             wr_en,
  input  wire logic [COL_W-1:0] wr_addr,
  input  wire line_word_t       wr_data,
  output line_word_t            rd_data
);

  line_word_t mem [MAX_WIDTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a write to the same column in this cycle is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

/* design/c3zp_window_mac.sv */
`default_nettype none

module c3zp_window_mac
  import c3zp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      col_valid,
  input  wire column_t   col,
  input  wire mac_ctrl_t col_ctrl,
  input  wire kernel_t   kernel,
  output logic           res_valid,
  output out_item_t      res_item
);

  pix_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] win;
  mac_ctrl_t win_ctrl;
  logic      win_valid;

  logic                     keep [KERNEL_SIZE][KERNEL_SIZE];
  logic signed [PROD_W-1:0] prod [KERNEL_SIZE][KERNEL_SIZE];
  logic                     prod_valid;
  logic                     prod_last;

  logic signed [RSUM_W-1:0] rsum [KERNEL_SIZE];
  logic                     rsum_valid;
  logic                     rsum_last;

  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  scaled;
  pix_t                     sat_value;

  // Window: shift one column in per input transaction, newest column on the right.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else begin
      win_valid <= col_valid && col_ctrl.out_en;
    end
    if (col_valid) begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
          win[r][c] <= win[r][c+1];
        end
      end
      win[0][KERNEL_SIZE-1] <= col.top;
      win[1][KERNEL_SIZE-1] <= col.mid;
      win[2][KERNEL_SIZE-1] <= col.bottom;
      win_ctrl <= col_ctrl;
    end
  end

  // Zero padding: a tap counts only when its row and column lie in the frame.
  always_comb begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE; c++) begin
        keep[r][c] = 1'b1;
        if (r == 0) keep[r][c] = keep[r][c] && win_ctrl.top_ok;
        if (r == KERNEL_SIZE - 1) keep[r][c] = keep[r][c] && win_ctrl.bottom_ok;
        if (c == 0) keep[r][c] = keep[r][c] && win_ctrl.left_ok;
        if (c == KERNEL_SIZE - 1) keep[r][c] = keep[r][c] && win_ctrl.right_ok;
      end
    end
  end

  // Nine products against the flipped kernel.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= win_valid;
    end
    prod_last <= win_ctrl.last;
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE; c++) begin
        if (keep[r][c]) begin
          prod[r][c] <= $signed(win[r][c]) *
            $signed(kernel[KERNEL_SIZE-1-r][COEF_W*(KERNEL_SIZE-1-c) +: COEF_W]);
        end else begin
          prod[r][c] <= '0;
        end
      end
    end
  end

  // Row sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsum_valid <= 1'b0;
    end else begin
      rsum_valid <= prod_valid;
    end
    rsum_last <= prod_last;
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      rsum[r] <= RSUM_W'(prod[r][0]) + RSUM_W'(prod[r][1]) + RSUM_W'(prod[r][2]);
    end
  end

  // Final sum, arithmetic shift that drops the twelve fraction bits of the Q4.12 coefficients, and saturation.
  always_comb begin
    acc = ACC_W'(rsum[0]) + ACC_W'(rsum[1]) + ACC_W'(rsum[2]);
    scaled = acc >>> FRAC_SHIFT;
    if (scaled > PIX_MAX) begin
      sat_value = PIX_W'(PIX_MAX);
    end else if (scaled < PIX_MIN) begin
      sat_value = PIX_W'(PIX_MIN);
    end else begin
      sat_value = scaled[PIX_W-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= rsum_valid;
    end
    res_item.filtered_value <= sat_value;
    res_item.frame_end      <= rsum_last;
  end

endmodule

`default_nettype wire

/* design/c3zp_out_fifo.sv */
`default_nettype none

module c3zp_out_fifo
  import c3zp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire out_item_t push_item,
  output logic           pop_valid,
  input  wire logic      pop_stall,
  output out_item_t      pop_item
);

  out_item_t            slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [CNT_W-1:0]     count;
  logic                 pop;

  assign pop_valid = (count != '0);
  assign pop_item  = slots[rd_ptr];
  assign pop       = pop_valid && !pop_stall;

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level. The caller never pushes into a full queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FIFO_AW'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

/* design/conv3x3_zero_padded_stream_top.sv */
// 3x3 convolution with zero padding over a raster pixel stream.
// Input channel (pixel_valid / pixel_stall / pixel_data): one pixel per
// transaction in raster order; after the last pixel of a frame the source
// sends frame_width+1 flush transactions (mode = 1) to drain the last outputs.
// Output channel (result_valid / result_stall / result_data): one convolved
// pixel per transaction, frame_end set on the last pixel of the frame.
// Configuration (cfg_write / cfg_index / cfg_data) is to be written while idle;
// the block does not enforce this. Throughput is one input transaction per
// clock while pixel_stall is low. A result's window is completed by the input
// transaction that arrives one row plus one pixel after the result's own pixel.
// The path is one line-store read, the window shift, a product stage, a row-sum
// stage and the result register, followed by an eight-entry result queue.
// When the receiver stalls, results collect in the queue; pixel_stall rises
// once eight results are owed, and drops as soon as one is taken.
// Reset clears the counters, the queue and the pipeline, and sets width to
// 1024, height to 1 and all coefficients to zero. The line store is not
// cleared: its contents from before a frame only reach padded taps.
`default_nettype none

module conv3x3_zero_padded_stream_top
  import c3zp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pixel_valid,
  output logic                      pixel_stall,
  input  wire in_item_t             pixel_data,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output out_item_t                 result_data,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // Configuration.
  logic [WIDTH_W-1:0]          eff_w;
  logic [HEIGHT_W-1:0]         eff_h;
  logic [TOTAL_W-1:0]          total;
  kernel_t                     kernel;
  logic [WIDTH_W-1:0]          eff_w_next;
  logic [HEIGHT_W-1:0]         eff_h_next;
  logic [WIDTH_W+HEIGHT_W-1:0] total_prod;

  // Stream position counters.
  logic [POS_W-1:0] n_pos;
  logic [COL_W-1:0] in_col;
  logic [POS_W-1:0] p_pos;
  logic [COL_W-1:0] out_x;
  logic [ROW_W-1:0] out_y;

  logic             accept;
  logic             out_now;
  logic             out_last;
  logic             in_col_wrap;
  logic             out_x_wrap;
  logic [POS_W-1:0] out_threshold;
  mac_ctrl_t        ctrl_now;

  // First pipeline stage.
  logic       s1_valid;
  pix_t       s1_pix;
  logic [COL_W-1:0] s1_col;
  mac_ctrl_t  s1_ctrl;

  line_word_t line_rd;
  line_word_t line_wr;
  column_t    s1_column;

  logic       mac_valid;
  out_item_t  mac_item;
  logic       result_pop;
  logic [CNT_W-1:0] pending;

  // Configuration writes; frame size is clamped and the pixel count kept ready.
  always_comb begin
    eff_w_next = eff_w;
    eff_h_next = eff_h;
    if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  eff_w_next = eff_width(cfg_data[WIDTH_W-1:0]);
        CFG_FRAME_HEIGHT: eff_h_next = eff_height(cfg_data[HEIGHT_W-1:0]);
        default:          ;
      endcase
    end
    total_prod = eff_w_next * eff_h_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w  <= WIDTH_W'(MAX_WIDTH);
      eff_h  <= HEIGHT_W'(1);
      total  <= TOTAL_W'(MAX_WIDTH);
      kernel <= '0;
    end else begin
      eff_w <= eff_w_next;
      eff_h <= eff_h_next;
      total <= total_prod[TOTAL_W-1:0];
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_KERNEL_TOP:    kernel[0] <= cfg_data[KROW_W-1:0];
          CFG_KERNEL_MID:    kernel[1] <= cfg_data[KROW_W-1:0];
          CFG_KERNEL_BOTTOM: kernel[2] <= cfg_data[KROW_W-1:0];
          default:           ;
        endcase
      end
    end
  end

  // Output decision for the transaction at the input: an output is due once
  // the input runs one row plus one pixel ahead of the output position.
  assign accept        = pixel_valid && !pixel_stall;
  assign out_threshold = p_pos + POS_W'(eff_w) + POS_W'(1);
  assign out_now       = (n_pos >= out_threshold);
  assign out_last      = ((p_pos + POS_W'(1)) == POS_W'(total));
  assign in_col_wrap   = ((32'(in_col) + 32'd1) == 32'(eff_w));
  assign out_x_wrap    = ((32'(out_x) + 32'd1) == 32'(eff_w));

  always_comb begin
    ctrl_now.out_en    = out_now;
    ctrl_now.last      = out_last;
    ctrl_now.top_ok    = (out_y != '0);
    ctrl_now.bottom_ok = ((32'(out_y) + 32'd1) != 32'(eff_h));
    ctrl_now.left_ok   = (out_x != '0);
    ctrl_now.right_ok  = !out_x_wrap;
  end

  // Position counters; everything returns to zero after the last output.
  always_ff @(posedge clk) begin
    if (rst) begin
      n_pos  <= '0;
      in_col <= '0;
      p_pos  <= '0;
      out_x  <= '0;
      out_y  <= '0;
    end else if (accept) begin
      if (out_now && out_last) begin
        n_pos  <= '0;
        in_col <= '0;
        p_pos  <= '0;
        out_x  <= '0;
        out_y  <= '0;
      end else begin
        n_pos  <= n_pos + POS_W'(1);
        in_col <= in_col_wrap ? '0 : in_col + COL_W'(1);
        if (out_now) begin
          p_pos <= p_pos + POS_W'(1);
          if (out_x_wrap) begin
            out_x <= '0;
            out_y <= out_y + ROW_W'(1);
          end else begin
            out_x <= out_x + COL_W'(1);
          end
        end
      end
    end
  end

  // First stage: holds the pixel while the line store returns its column.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_pix  <= pixel_data.mode ? '0 : pixel_data.pixel_value;
      s1_col  <= in_col;
      s1_ctrl <= ctrl_now;
    end
  end

  // The line store shifts by one row: the new pixel goes to the near row and
  // the old near row moves to the far row.
  always_comb begin
    line_wr.near_row = s1_pix;
    line_wr.far_row  = line_rd.near_row;
    s1_column.top    = line_rd.far_row;
    s1_column.mid    = line_rd.near_row;
    s1_column.bottom = s1_pix;
  end

  c3zp_line_store u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_col),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (line_wr),
    .rd_data (line_rd)
  );

  c3zp_window_mac u_window_mac (
    .clk       (clk),
    .rst       (rst),
    .col_valid (s1_valid),
    .col       (s1_column),
    .col_ctrl  (s1_ctrl),
    .kernel    (kernel),
    .res_valid (mac_valid),
    .res_item  (mac_item)
  );

  c3zp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (mac_valid),
    .push_item (mac_item),
    .pop_valid (result_valid),
    .pop_stall (result_stall),
    .pop_item  (result_data)
  );

  // Results owed: accepted transactions that cause an output, not yet taken.
  assign result_pop  = result_valid && !result_stall;
  assign pixel_stall = (pending == CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + CNT_W'(accept && out_now) - CNT_W'(result_pop);
    end
  end

  // The credit count bounds the queue fill.
  assert property (@(posedge clk) disable iff (rst)
    pending <= CNT_W'(FIFO_DEPTH))
    else $error("result credit count exceeds queue depth");

  // The last output of a frame restarts n_pos, p_pos and in_col.
  assert property (@(posedge clk) disable iff (rst)
    accept && out_now && out_last |=> (n_pos == '0) && (p_pos == '0) && (in_col == '0))
    else $error("counters not cleared after the last output of a frame");

  // A result can only leave the datapath when one is owed.
  assert property (@(posedge clk) disable iff (rst)
    mac_valid |-> (pending != '0))
    else $error("datapath produced a result that no transaction asked for");

  // A result offered downstream is always covered by the credit count.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (pending != '0))
    else $error("result offered with no credit outstanding");

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import c3zp_pkg::*;

  // Item kinds on the pixel channel.
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // An index past the last register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  localparam int LINE_DEPTH    = (KERNEL_SIZE - 1) * MAX_WIDTH + KERNEL_SIZE;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 24;
  localparam int RANDOM_ITEMS  = 480;
  localparam int CYCLE_LIMIT   = 2000000;

  logic                 clk;
  logic                 rst;
  logic                 pixel_valid;
  logic                 pixel_stall;
  in_item_t             pixel_data;
  logic                 result_valid;
  logic                 result_stall;
  out_item_t            result_data;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Copy of the block's configuration and stream state.
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [KROW_W-1:0]   kern_rows [KERNEL_SIZE];
  pix_t                line_hist [LINE_DEPTH];
  int                  in_col;
  int                  in_row;
  int                  out_pos;

  out_item_t owed_outputs[$];
  int        mismatch_count;
  int        cycle_count;
  int        items_sent;
  bit        quiet;

  conv3x3_zero_padded_stream_top u_top (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_data   (pixel_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Effective frame size after the block's clamping.
  function automatic int frame_cols();
    if (width_reg == '0) return 1;
    if (int'(width_reg) > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int frame_rows();
    if (height_reg == '0) return 1;
    if (int'(height_reg) > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return int'(height_reg);
  endfunction

  // Advance the stream state by one accepted transaction and queue the
  // convolved pixel it completes, if any.
  task automatic compute_output(input in_item_t it);
    int      cols;
    int      rows;
    int      total;
    int      p;
    int      n;
    int      xx;
    int      yy;
    longint  acc;
    pix_t    tap;
    pix_t    coef;
    out_item_t res;
    cols = frame_cols();
    rows = frame_rows();
    total = cols * rows;
    acc = 0;
    if (out_pos >= total) begin
      in_col = 0;
      in_row = 0;
      out_pos = 0;
    end
    p = out_pos;
    n = in_row * cols + in_col;
    // A flush inside the frame stores a zero pixel; past the frame nothing is stored.
    if (n < total) begin
      line_hist[n % LINE_DEPTH] = (it.mode == MODE_FLUSH) ? pix_t'(0) : it.pixel_value;
    end
    in_col++;
    if (in_col >= cols) begin
      in_col = 0;
      in_row++;
    end
    if (n + 1 >= p + cols + 2) begin
      // Flipped kernel: tap at offset (dx, dy) uses row 1-dy, column 1-dx.
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          xx = p % cols + dx;
          yy = p / cols + dy;
          tap = '0;
          if (xx >= 0 && yy >= 0 && xx < cols && yy < rows) begin
            tap = line_hist[(yy * cols + xx) % LINE_DEPTH];
          end
          coef = kern_rows[1 - dy][COEF_W * (1 - dx) +: COEF_W];
          acc += longint'(tap) * longint'(coef);
        end
      end
      acc = acc >>> FRAC_SHIFT;
      if (acc > PIX_MAX) acc = PIX_MAX;
      if (acc < PIX_MIN) acc = PIX_MIN;
      res.filtered_value = pix_t'(acc);
      res.frame_end = (p + 1 == total);
      owed_outputs.push_back(res);
      p++;
      if (p >= total) begin
        in_col = 0;
        in_row = 0;
        out_pos = 0;
      end else begin
        out_pos = p;
      end
    end
  endtask

  // Gap length before the next transaction: mostly none, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 16);
  endfunction

  function automatic pix_t pick_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'sh7FFF;
    if (r < 16) return 16'sh8000;
    if (r < 20) return '0;
    if (r < 60) return pix_t'(int'($urandom_range(0, 2047)) - 1024);
    return pix_t'($urandom);
  endfunction

  function automatic logic [KROW_W-1:0] pick_kernel_row();
    logic [KROW_W-1:0] row;
    int r;
    for (int c = 0; c < KERNEL_SIZE; c++) begin
      r = $urandom_range(0, 99);
      if (r < 12) row[COEF_W * c +: COEF_W] = 16'h7FFF;
      else if (r < 24) row[COEF_W * c +: COEF_W] = 16'h8000;
      else if (r < 34) row[COEF_W * c +: COEF_W] = '0;
      else if (r < 70) row[COEF_W * c +: COEF_W] = COEF_W'(int'($urandom_range(0, 8191)) - 4096);
      else row[COEF_W * c +: COEF_W] = COEF_W'($urandom);
    end
    return row;
  endfunction

  // One register write; the copy of the configuration follows it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_FRAME_WIDTH:   width_reg = value[WIDTH_W-1:0];
      CFG_FRAME_HEIGHT:  height_reg = value[HEIGHT_W-1:0];
      CFG_KERNEL_TOP:    kern_rows[0] = value;
      CFG_KERNEL_MID:    kern_rows[1] = value;
      CFG_KERNEL_BOTTOM: kern_rows[2] = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Frame size writes carry random bits above the register width.
  task automatic set_geometry(input int cols, input int rows);
    logic [CFG_W-1:0] d;
    d = {16'($urandom), $urandom};
    d[WIDTH_W-1:0] = WIDTH_W'(cols);
    write_reg(CFG_FRAME_WIDTH, d);
    d = {16'($urandom), $urandom};
    d[HEIGHT_W-1:0] = HEIGHT_W'(rows);
    write_reg(CFG_FRAME_HEIGHT, d);
  endtask

  // Send one transaction on the pixel channel, then an optional gap.
  task automatic send_pixel(input logic m, input pix_t v);
    in_item_t it;
    int gap;
    it.mode = m;
    it.pixel_value = v;
    @(negedge clk);
    pixel_valid <= 1'b1;
    pixel_data  <= it;
    do @(posedge clk); while (pixel_stall);
    compute_output(it);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      pixel_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold the source idle until every owed output has been taken.
  task automatic wait_for_outputs();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (owed_outputs.size() != 0) @(posedge clk);
  endtask

  // Drained and past the pipeline, so registers may be written.
  task automatic settle();
    wait_for_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One whole frame plus its flush tail. A broken frame has stray flushes
  // inside and pixels in the tail.
  task automatic send_frame(input bit broken, input bit pause_once);
    int cols;
    int total;
    int pause_at;
    cols = frame_cols();
    total = cols * frame_rows();
    pause_at = pause_once ? $urandom_range(0, total - 1) : -1;
    quiet = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < total; i++) begin
      if (i == pause_at) wait_for_outputs();
      send_pixel((broken && $urandom_range(0, 19) == 0) ? MODE_FLUSH : MODE_PIXEL, pick_pixel());
    end
    for (int i = 0; i <= cols; i++) begin
      send_pixel((broken && $urandom_range(0, 1) == 0) ? MODE_PIXEL : MODE_FLUSH, pick_pixel());
    end
  endtask

  // Reset values: a single row through an all-zero kernel; only the width
  // is written.
  task automatic test_reset_values();
    write_reg(CFG_FRAME_WIDTH, CFG_W'($urandom_range(2, 8)));
    send_frame(1'b0, 1'b0);
  endtask

  // Saturation both ways, mixed extreme coefficients, a flush inside the
  // frame and a pixel inside the flush tail.
  task automatic test_corner_values();
    pix_t mixed_pix [6] = '{16'sh7FFF, 16'sh8000, 16'sh5555, 16'shFFFF, 16'sh0001, 16'sh1234};
    settle();
    set_geometry(2, 2);
    write_reg(CFG_KERNEL_TOP, {KERNEL_SIZE{16'h7FFF}});
    write_reg(CFG_KERNEL_MID, {KERNEL_SIZE{16'h7FFF}});
    write_reg(CFG_KERNEL_BOTTOM, {KERNEL_SIZE{16'h7FFF}});
    for (int i = 0; i < 4; i++) send_pixel(MODE_PIXEL, 16'sh7FFF);
    for (int i = 0; i < 3; i++) send_pixel(MODE_FLUSH, pick_pixel());
    for (int i = 0; i < 4; i++) send_pixel(MODE_PIXEL, 16'sh8000);
    for (int i = 0; i < 3; i++) send_pixel(MODE_FLUSH, 16'sh7FFF);
    settle();
    set_geometry(3, 2);
    write_reg(CFG_KERNEL_TOP, {16'h8000, 16'h0001, 16'hFFFF});
    write_reg(CFG_KERNEL_MID, {16'h1000, 16'h7FFF, 16'h0000});
    write_reg(CFG_KERNEL_BOTTOM, {16'hF000, 16'h8000, 16'h0FFF});
    for (int i = 0; i < 6; i++) begin
      if (i == 3) wait_for_outputs();
      send_pixel((i == 2) ? MODE_FLUSH : MODE_PIXEL, mixed_pix[i]);
    end
    for (int i = 0; i < 4; i++) begin
      send_pixel((i == 1) ? MODE_PIXEL : MODE_FLUSH, (i == 1) ? 16'sh7FFF : 16'shFFFF);
    end
  endtask

  // A zero frame width or height acts as one.
  task automatic test_size_clamps();
    settle();
    set_geometry(0, 0);
    write_reg(CFG_KERNEL_TOP, pick_kernel_row());
    write_reg(CFG_KERNEL_MID, pick_kernel_row());
    write_reg(CFG_KERNEL_BOTTOM, pick_kernel_row());
    send_frame(1'b0, 1'b0);
    settle();
    set_geometry(0, 4);
    send_frame(1'b0, 1'b0);
    settle();
    set_geometry(5, 0);
    send_frame(1'b0, 1'b1);
  endtask

  // Random geometry and kernels, one to three frames per setting.
  task automatic test_random_frames();
    int start;
    int r;
    int cols;
    int rows;
    bit first;
    start = items_sent;
    first = 1'b1;
    while (items_sent - start < RANDOM_ITEMS) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 5) cols = 0;
      else if (r < 75) cols = $urandom_range(1, 8);
      else if (r < 95) cols = $urandom_range(9, 40);
      else cols = $urandom_range(41, 64);
      r = $urandom_range(0, 99);
      if (r < 5) rows = 0;
      else if (r < 80) rows = $urandom_range(1, 6);
      else rows = $urandom_range(7, 12);
      set_geometry(cols, rows);
      if (first || $urandom_range(0, 9) < 6) write_reg(CFG_KERNEL_TOP, pick_kernel_row());
      if (first || $urandom_range(0, 9) < 6) write_reg(CFG_KERNEL_MID, pick_kernel_row());
      if (first || $urandom_range(0, 9) < 6) write_reg(CFG_KERNEL_BOTTOM, pick_kernel_row());
      if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE, {16'($urandom), $urandom});
      first = 1'b0;
      repeat ($urandom_range(1, 3)) begin
        send_frame($urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // Receiver stalls come in runs: mostly short, a few long.
  initial begin
    int hold;
    bit level;
    hold = 0;
    level = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        level = ($urandom_range(0, 99) < 35);
        if (!level) hold = $urandom_range(1, 6);
        else if ($urandom_range(0, 9) == 0) hold = $urandom_range(8, 16);
        else hold = $urandom_range(1, 3);
      end
      hold--;
      result_stall <= level && !quiet;
    end
  end

  // Compare each output transaction with the oldest owed output.
  always @(posedge clk) begin
    out_item_t exp_out;
    if (!rst && result_valid && !result_stall) begin
      if (owed_outputs.size() == 0) begin
        $display("%0t: output %0d / frame_end %0b arrived with none owed",
                 $time, result_data.filtered_value, result_data.frame_end);
        mismatch_count++;
      end else begin
        exp_out = owed_outputs.pop_front();
        if (result_data.filtered_value !== exp_out.filtered_value) begin
          $display("%0t: filtered_value expected %0d, got %0d",
                   $time, exp_out.filtered_value, result_data.filtered_value);
          mismatch_count++;
        end
        if (result_data.frame_end !== exp_out.frame_end) begin
          $display("%0t: frame_end expected %0b, got %0b",
                   $time, exp_out.frame_end, result_data.frame_end);
          mismatch_count++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    pixel_valid = 1'b0;
    pixel_data = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    items_sent = 0;
    width_reg = WIDTH_W'(MAX_WIDTH);
    height_reg = HEIGHT_W'(1);
    for (int k = 0; k < KERNEL_SIZE; k++) kern_rows[k] = '0;
    for (int a = 0; a < LINE_DEPTH; a++) line_hist[a] = '0;
    in_col = 0;
    in_row = 0;
    out_pos = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_corner_values();
    test_size_clamps();
    test_random_frames();

    wait_for_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
